### hw/rtl/mpbc_pkg.sv
package mpbc_pkg;

    // Fixed shape of the payload and the code table.
    localparam int CODES_PER_BUTTON = 8;
    localparam int ROM_ROWS         = 9;
    localparam int MAX_BUTTONS      = 15;
    localparam int ACT_W            = 4;
    localparam int CNT_W            = 8;
    localparam int CFG_IDX_W        = 3;
    localparam int CFG_DATA_W       = 16;

    // Defaults for the top-level parameters.
    localparam int NUM_BUTTONS_DEF = 9;
    localparam int TIME_BITS_DEF   = 32;

    // Active-button code that means no button owns the request.
    localparam logic [ACT_W-1:0] NONE_ACTIVE = 4'd15;
    localparam logic [CNT_W-1:0] CNT_MAX     = 8'hFF;

    // Columns of the code table.
    localparam logic [2:0] COL_SINGLE    = 3'd0;
    localparam logic [2:0] COL_DOUBLE    = 3'd1;
    localparam logic [2:0] COL_SEXTUPLE  = 3'd5;
    localparam logic [2:0] COL_LONG      = 3'd6;
    localparam logic [2:0] COL_REPEAT    = 3'd7;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LONG_PRESS   = 3'd0,
        REG_REPEAT_PRESS = 3'd1,
        REG_DEBOUNCE     = 3'd2,
        REG_DOUBLE_GAP   = 3'd3,
        REG_MULTI_GAP    = 3'd4,
        REG_WAIT_TIMEOUT = 3'd5
    } cfg_reg_t;

    // Reset values of the configuration registers.
    localparam logic [CFG_DATA_W-1:0] LONG_PRESS_RST   = 16'd800;
    localparam logic [CFG_DATA_W-1:0] REPEAT_PRESS_RST = 16'd500;
    localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RST     = 16'd50;
    localparam logic [CFG_DATA_W-1:0] DOUBLE_GAP_RST   = 16'd300;
    localparam logic [CFG_DATA_W-1:0] MULTI_GAP_RST    = 16'd300;
    localparam logic [CFG_DATA_W-1:0] WAIT_TIMEOUT_RST = 16'd5000;

    typedef struct packed {
        logic [7:0]  button_bits;
        logic        moon_pressed;
        logic [31:0] now_ms;
        logic        wait_for_press;
        logic        call_start;
    } poll_t;

    typedef struct packed {
        logic       decided;
        logic [7:0] press_code;
        logic       is_repeat;
    } result_t;

    // Column 0 is single, columns 1 to 5 are double to sextuple, column 6 is
    // long and column 7 is repeat. A zero entry means the press type is unused.
    localparam logic [7:0] CODE_ROM [ROM_ROWS][CODES_PER_BUTTON] = '{
        '{8'd2,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd102, 8'd0},
        '{8'd1,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd101, 8'd0},
        '{8'd17, 8'd27, 8'd37, 8'd47, 8'd57, 8'd67, 8'd117, 8'd0},
        '{8'd16, 8'd26, 8'd36, 8'd46, 8'd56, 8'd66, 8'd116, 8'd0},
        '{8'd19, 8'd29, 8'd39, 8'd49, 8'd59, 8'd69, 8'd119, 8'd0},
        '{8'd18, 8'd28, 8'd38, 8'd48, 8'd58, 8'd68, 8'd118, 8'd0},
        '{8'd9,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd109, 8'd0},
        '{8'd8,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd108, 8'd0},
        '{8'd3,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd103, 8'd0}
    };

    // Rows past the table belong to buttons without a code and read as zero.
    function automatic logic [7:0] rom_code(input logic [ACT_W-1:0] row,
                                            input logic [2:0] col);
        logic [7:0] code;
        code = 8'd0;
        if (int'(row) < ROM_ROWS) begin
            code = CODE_ROM[row][col];
        end
        return code;
    endfunction

    function automatic logic btn_long(input logic [ACT_W-1:0] row);
        return rom_code(row, COL_LONG) != 8'd0;
    endfunction

    function automatic logic btn_multi(input logic [ACT_W-1:0] row);
        return rom_code(row, COL_DOUBLE) != 8'd0;
    endfunction

    function automatic logic btn_repeat(input logic [ACT_W-1:0] row);
        return (rom_code(row, COL_REPEAT) != 8'd0) && !btn_long(row);
    endfunction

    function automatic logic btn_single(input logic [ACT_W-1:0] row);
        return (rom_code(row, COL_SINGLE) != 8'd0) && !btn_repeat(row)
            && !btn_long(row) && !btn_multi(row);
    endfunction

endpackage

### hw/rtl/multi_press_button_classifier_unit.sv
// Multi-press button classifier.
// Each transfer on the poll channel carries one sample of the button levels
// (eight buttons plus the sleep button), a millisecond timestamp and two
// request flags. For every poll the block returns exactly one transfer on the
// result channel: decided, the press code and the repeat flag.
// A poll is registered in an input stage; the priority scan over all buttons
// then runs on it in one pass of logic, and as the output register frees up
// the per-button state is updated and the result is loaded into that register.
// When the result channel does not stall, a poll can be taken on every cycle,
// set by the single scan between input and output registers.
// When the result channel is stalled the output register holds its result,
// the input stage keeps one more poll and then poll_stall is raised until the
// result is taken. No poll is lost or duplicated.
// Reset clears all per-button state, sets no active button and loads the
// timing registers with their default values. The timing registers are
// written through the cfg port, one 16-bit register per write; the user must
// write them only while the block is idle, which the block does not enforce.
module multi_press_button_classifier_unit #(
    parameter int NUM_BUTTONS = mpbc_pkg::NUM_BUTTONS_DEF,
    parameter int TIME_BITS   = mpbc_pkg::TIME_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                poll_valid,
    output logic                                poll_stall,
    input  mpbc_pkg::poll_t                     poll,
    output logic                                result_valid,
    input  logic                                result_stall,
    output mpbc_pkg::result_t                   result,
    input  logic                                cfg_we,
    input  logic [mpbc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mpbc_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int ACT_W = mpbc_pkg::ACT_W;
    localparam int CNT_W = mpbc_pkg::CNT_W;

    typedef logic [TIME_BITS-1:0] stamp_t;
    typedef logic [ACT_W-1:0]     act_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    // Timing registers.
    logic [mpbc_pkg::CFG_DATA_W-1:0] long_press_reg;
    logic [mpbc_pkg::CFG_DATA_W-1:0] repeat_press_reg;
    logic [mpbc_pkg::CFG_DATA_W-1:0] debounce_reg;
    logic [mpbc_pkg::CFG_DATA_W-1:0] double_gap_reg;
    logic [mpbc_pkg::CFG_DATA_W-1:0] multi_gap_reg;
    logic [mpbc_pkg::CFG_DATA_W-1:0] wait_timeout_reg;

    // Pipeline registers.
    logic                 stage_valid_reg;
    logic                 stage_valid_next;
    mpbc_pkg::poll_t      stage_reg;
    logic                 result_valid_reg;
    logic                 result_valid_next;
    mpbc_pkg::result_t    result_reg;
    mpbc_pkg::result_t    result_next;

    // Per-button state.
    cnt_t                   click_count_reg [NUM_BUTTONS];
    cnt_t                   click_count_next [NUM_BUTTONS];
    stamp_t                 press_start_reg [NUM_BUTTONS];
    stamp_t                 press_start_next [NUM_BUTTONS];
    stamp_t                 last_edge_reg [NUM_BUTTONS];
    stamp_t                 last_edge_next [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] held_reg;
    logic [NUM_BUTTONS-1:0] held_next;
    logic [NUM_BUTTONS-1:0] long_fired_reg;
    logic [NUM_BUTTONS-1:0] long_fired_next;
    logic [NUM_BUTTONS-1:0] repeat_fired_reg;
    logic [NUM_BUTTONS-1:0] repeat_fired_next;
    act_t                   active_reg;
    act_t                   active_next;
    stamp_t                 req_start_reg;
    stamp_t                 req_start_next;

    logic poll_take;
    logic advance;

    stamp_t                            now_t;
    act_t                              act_start;
    logic                              timeout_hit;
    logic [mpbc_pkg::MAX_BUTTONS-1:0]  level_all;
    logic [NUM_BUTTONS-1:0]            pressed;
    logic [NUM_BUTTONS-1:0]            long_hit;
    logic [NUM_BUTTONS-1:0]            repeat_hit;
    logic [NUM_BUTTONS-1:0]            debounce_hit;
    logic [NUM_BUTTONS-1:0]            gap_one_hit;
    logic [NUM_BUTTONS-1:0]            gap_multi_hit;

    // Handshake. The scan result moves to the output register whenever that
    // register is empty or its result is being taken this cycle.
    assign advance    = stage_valid_reg && (!result_valid_reg || !result_stall);
    assign poll_stall = stage_valid_reg && result_valid_reg && result_stall;
    assign poll_take  = poll_valid && !poll_stall;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (poll_take) begin
            stage_valid_next = 1'b1;
        end else if (advance) begin
            stage_valid_next = 1'b0;
        end
        result_valid_next = advance || (result_valid_reg && result_stall);
    end

    // Poll decoding. Buttons past the sleep button have no input and read
    // as released.
    assign now_t     = stamp_t'(stage_reg.now_ms);
    assign level_all = mpbc_pkg::MAX_BUTTONS'({stage_reg.moon_pressed,
                                               stage_reg.button_bits});
    assign pressed   = level_all[NUM_BUTTONS-1:0];

    // A call start latches the request time before the timeout is checked.
    assign req_start_next = stage_reg.call_start ? now_t : req_start_reg;
    assign act_start      = (active_reg < act_t'(NUM_BUTTONS)) ? active_reg
                                                               : mpbc_pkg::NONE_ACTIVE;
    assign timeout_hit    = stage_reg.wait_for_press
                         && (act_start == mpbc_pkg::NONE_ACTIVE)
                         && ((now_t - req_start_next) >= stamp_t'(wait_timeout_reg));

    // Time comparisons for every button, independent of the scan order.
    always_comb
    begin
        stamp_t dur;
        stamp_t gap;
        for (int i = 0; i < NUM_BUTTONS; i++) begin
            dur              = now_t - press_start_reg[i];
            gap              = now_t - last_edge_reg[i];
            long_hit[i]      = dur >= stamp_t'(long_press_reg);
            repeat_hit[i]    = dur >= stamp_t'(repeat_press_reg);
            debounce_hit[i]  = dur > stamp_t'(debounce_reg);
            gap_one_hit[i]   = gap > stamp_t'(double_gap_reg);
            gap_multi_hit[i] = gap > stamp_t'(multi_gap_reg);
        end
    end

    // Priority scan. Buttons are visited in index order and the first rule
    // that decides the poll stops the scan; later buttons keep their state.
    // Only the active-button code, the decision flag and the click counts cleared
    // by a new press ripple from one button to the next.
    always_comb
    begin
        act_t       act;
        logic       done;
        logic       p;
        logic       h;
        act_t       row;
        logic [2:0] col;
        logic [7:0] code;
        logic       rep;

        click_count_next  = click_count_reg;
        press_start_next  = press_start_reg;
        last_edge_next    = last_edge_reg;
        held_next         = held_reg;
        long_fired_next   = long_fired_reg;
        repeat_fired_next = repeat_fired_reg;
        act  = act_start;
        done = timeout_hit;
        code = 8'd0;
        rep  = 1'b0;
        p    = 1'b0;
        h    = 1'b0;
        row  = '0;
        col  = mpbc_pkg::COL_SINGLE;

        for (int j = 0; j < NUM_BUTTONS; j++) begin
            if (!done) begin
                p   = pressed[j];
                h   = held_reg[j];
                row = act_t'(j);
                if (!p && !h && act == row && click_count_next[j] == '0) begin
                    // The active button was released without a click.
                    act  = mpbc_pkg::NONE_ACTIVE;
                    done = 1'b1;
                end else if (!p && !h && act == mpbc_pkg::NONE_ACTIVE
                             && j == NUM_BUTTONS - 1 && !stage_reg.wait_for_press) begin
                    done = 1'b1;
                end else if (p && !h) begin
                    // A new press takes over and drops the clicks of the
                    // button that was active before.
                    for (int k = 0; k < NUM_BUTTONS; k++) begin
                        if (act != row && act == act_t'(k)) begin
                            click_count_next[k] = '0;
                        end
                    end
                    press_start_next[j] = now_t;
                    last_edge_next[j]   = now_t;
                    act                 = row;
                    if (mpbc_pkg::btn_single(row)) begin
                        code = mpbc_pkg::rom_code(row, mpbc_pkg::COL_SINGLE);
                        done = 1'b1;
                    end else if (!mpbc_pkg::btn_multi(row) && !mpbc_pkg::btn_long(row)
                                 && !mpbc_pkg::btn_repeat(row)) begin
                        done = 1'b1;
                    end else begin
                        held_next[j] = 1'b1;
                    end
                end else if (p && h && mpbc_pkg::btn_long(row)) begin
                    if (long_hit[j]) begin
                        long_fired_next[j] = 1'b1;
                        code = mpbc_pkg::rom_code(row, mpbc_pkg::COL_LONG);
                        done = 1'b1;
                    end
                end else if (p && h && mpbc_pkg::btn_repeat(row)) begin
                    if (repeat_hit[j]) begin
                        repeat_fired_next[j] = 1'b1;
                        code = mpbc_pkg::rom_code(row, mpbc_pkg::COL_REPEAT);
                        rep  = 1'b1;
                        done = 1'b1;
                    end
                end else if (!p && h && (long_fired_reg[j] || repeat_fired_reg[j])) begin
                    held_next[j]         = 1'b0;
                    long_fired_next[j]   = 1'b0;
                    repeat_fired_next[j] = 1'b0;
                    code = mpbc_pkg::rom_code(row, mpbc_pkg::COL_SINGLE);
                    done = 1'b1;
                end else if (!p && h && !mpbc_pkg::btn_multi(row)) begin
                    held_next[j] = 1'b0;
                    code = mpbc_pkg::rom_code(row, mpbc_pkg::COL_SINGLE);
                    done = 1'b1;
                end else if (!p && h) begin
                    // Release of a multi-press button counts a click. The gap
                    // starts now, so this button cannot decide by count in this poll.
                    held_next[j] = 1'b0;
                    if (debounce_hit[j] && click_count_next[j] != mpbc_pkg::CNT_MAX) begin
                        click_count_next[j] = click_count_next[j] + cnt_t'(1);
                    end
                    last_edge_next[j] = now_t;
                end else if (!p && !h && click_count_next[j] != '0
                             && mpbc_pkg::btn_multi(row)) begin
                    // Quiet gap after clicks decides by count; more than six
                    // clicks give the sextuple code.
                    if (click_count_next[j] == cnt_t'(1) && gap_one_hit[j]) begin
                        click_count_next[j] = '0;
                        code = mpbc_pkg::rom_code(row, mpbc_pkg::COL_SINGLE);
                        done = 1'b1;
                    end else if (click_count_next[j] >= cnt_t'(2) && gap_multi_hit[j]) begin
                        col = (click_count_next[j] > cnt_t'(6))
                            ? mpbc_pkg::COL_SEXTUPLE
                            : 3'(click_count_next[j] - cnt_t'(1));
                        click_count_next[j] = '0;
                        code = mpbc_pkg::rom_code(row, col);
                        done = 1'b1;
                    end
                end
            end
        end

        active_next            = act;
        result_next.decided    = done;
        result_next.press_code = code;
        result_next.is_repeat  = rep;
    end

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            long_press_reg   <= mpbc_pkg::LONG_PRESS_RST;
            repeat_press_reg <= mpbc_pkg::REPEAT_PRESS_RST;
            debounce_reg     <= mpbc_pkg::DEBOUNCE_RST;
            double_gap_reg   <= mpbc_pkg::DOUBLE_GAP_RST;
            multi_gap_reg    <= mpbc_pkg::MULTI_GAP_RST;
            wait_timeout_reg <= mpbc_pkg::WAIT_TIMEOUT_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                mpbc_pkg::REG_LONG_PRESS:   long_press_reg   <= cfg_data;
                mpbc_pkg::REG_REPEAT_PRESS: repeat_press_reg <= cfg_data;
                mpbc_pkg::REG_DEBOUNCE:     debounce_reg     <= cfg_data;
                mpbc_pkg::REG_DOUBLE_GAP:   double_gap_reg   <= cfg_data;
                mpbc_pkg::REG_MULTI_GAP:    multi_gap_reg    <= cfg_data;
                mpbc_pkg::REG_WAIT_TIMEOUT: wait_timeout_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Control and button state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            stage_valid_reg  <= 1'b0;
            result_valid_reg <= 1'b0;
            held_reg         <= '0;
            long_fired_reg   <= '0;
            repeat_fired_reg <= '0;
            active_reg       <= mpbc_pkg::NONE_ACTIVE;
            req_start_reg    <= '0;
            for (int i = 0; i < NUM_BUTTONS; i++) begin
                click_count_reg[i] <= '0;
                press_start_reg[i] <= '0;
                last_edge_reg[i]   <= '0;
            end
        end else begin
            stage_valid_reg  <= stage_valid_next;
            result_valid_reg <= result_valid_next;
            if (advance) begin
                held_reg         <= held_next;
                long_fired_reg   <= long_fired_next;
                repeat_fired_reg <= repeat_fired_next;
                active_reg       <= active_next;
                req_start_reg    <= req_start_next;
                click_count_reg  <= click_count_next;
                press_start_reg  <= press_start_next;
                last_edge_reg    <= last_edge_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (poll_take) begin
            stage_reg <= poll;
        end
        if (advance) begin
            result_reg <= result_next;
        end
    end

    // Every poll that leaves the input stage shows up as a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid_reg)
        else $error("scanned poll did not reach the output register");

    // Long and repeat flags only live while their button is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((long_fired_reg | repeat_fired_reg) & ~held_reg) == '0)
        else $error("fired flag set on a released button");

    // A repeat code is always a decision.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.is_repeat |-> result_reg.decided)
        else $error("repeat flag without a decision");

    // The active button is a real button or none.
    assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg == mpbc_pkg::NONE_ACTIVE) || (active_reg < act_t'(NUM_BUTTONS)))
        else $error("active button out of range");

endmodule

### tb/sv/multi_press_button_classifier_unit_tb.sv
`timescale 1ns / 1ps

module multi_press_button_classifier_unit_tb;

    localparam int BUTTONS     = mpbc_pkg::NUM_BUTTONS_DEF;
    localparam int QUIET_LIMIT = 4000;
    localparam int PHASE_POLLS = 100;

    // Press codes per button. Column order follows the package column names:
    // single, double to sextuple, long, repeat. A zero means the press type
    // does not exist for that button.
    localparam logic [7:0] BUTTON_CODES [9][8] = '{
        '{8'd2,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd102, 8'd0},
        '{8'd1,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd101, 8'd0},
        '{8'd17, 8'd27, 8'd37, 8'd47, 8'd57, 8'd67, 8'd117, 8'd0},
        '{8'd16, 8'd26, 8'd36, 8'd46, 8'd56, 8'd66, 8'd116, 8'd0},
        '{8'd19, 8'd29, 8'd39, 8'd49, 8'd59, 8'd69, 8'd119, 8'd0},
        '{8'd18, 8'd28, 8'd38, 8'd48, 8'd58, 8'd68, 8'd118, 8'd0},
        '{8'd9,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd109, 8'd0},
        '{8'd8,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd108, 8'd0},
        '{8'd3,  8'd0,  8'd0,  8'd0,  8'd0,  8'd0,  8'd103, 8'd0}
    };

    // Every block input starts from a known value.
    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            poll_valid = 1'b0;
    logic                            poll_stall;
    mpbc_pkg::poll_t                 poll = '0;
    logic                            result_valid;
    logic                            result_stall = 1'b0;
    mpbc_pkg::result_t               result;
    logic                            cfg_we = 1'b0;
    logic [mpbc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [mpbc_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Timing registers as the block should currently hold them.
    logic [mpbc_pkg::CFG_DATA_W-1:0] timing [6];

    // Per-button press tracking kept by the predictor.
    logic [mpbc_pkg::CNT_W-1:0] clicks        [BUTTONS];
    logic [31:0]                press_at      [BUTTONS];
    logic [31:0]                last_change_at[BUTTONS];
    logic                       held          [BUTTONS];
    logic                       long_done     [BUTTONS];
    logic                       repeat_done   [BUTTONS];
    logic [mpbc_pkg::ACT_W-1:0] owner;
    logic [31:0]                request_at;

    // Polls waiting to be sent and press codes waiting to be returned.
    mpbc_pkg::poll_t   poll_backlog [$];
    mpbc_pkg::result_t expected_codes [$];

    logic [31:0] clock_ms = '0;
    int unsigned polls_queued = 0;
    int unsigned polls_taken = 0;
    int unsigned code_errors = 0;
    int          burst_left = 1;
    int          idle_left = 0;
    int          stall_mode = 0;
    int unsigned stall_tick = 0;
    int unsigned quiet_cycles = 0;

    multi_press_button_classifier_unit u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .poll_valid   (poll_valid),
        .poll_stall   (poll_stall),
        .poll         (poll),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    // Works out the press code for one poll and advances the tracked state.
    // Buttons are scanned from index zero upward and the first rule that
    // fires decides the poll; when no rule fires the result is undecided.
    function automatic mpbc_pkg::result_t classify_poll(input mpbc_pkg::poll_t p);
        mpbc_pkg::result_t r;
        logic [31:0]       dur;
        logic [31:0]       gap;
        logic [31:0]       since_request;
        logic              pressed;
        logic              has_multi;
        logic              has_long;
        logic              has_repeat;
        logic              single_only;
        logic              no_owner;
        int                n;
        r = '0;
        if (p.call_start)
        begin
            request_at = p.now_ms;
        end
        if (owner >= BUTTONS)
        begin
            owner = mpbc_pkg::NONE_ACTIVE;
        end
        since_request = p.now_ms - request_at;
        // A waiting request with no button in play gives up after the timeout.
        if (p.wait_for_press && owner == mpbc_pkg::NONE_ACTIVE
            && since_request >= 32'(timing[mpbc_pkg::REG_WAIT_TIMEOUT]))
        begin
            r.decided = 1'b1;
            return r;
        end
        for (int i = 0; i < BUTTONS; i++)
        begin
            if (i < 8)
            begin
                pressed = p.button_bits[i];
            end
            else
            begin
                pressed = (i == 8) ? p.moon_pressed : 1'b0;
            end
            has_multi   = BUTTON_CODES[i][mpbc_pkg::COL_DOUBLE] != 8'd0;
            has_long    = BUTTON_CODES[i][mpbc_pkg::COL_LONG] != 8'd0;
            has_repeat  = (BUTTON_CODES[i][mpbc_pkg::COL_REPEAT] != 8'd0) && !has_long;
            single_only = (BUTTON_CODES[i][mpbc_pkg::COL_SINGLE] != 8'd0) && !has_repeat
                          && !has_long && !has_multi;
            dur         = p.now_ms - press_at[i];
            no_owner    = (owner == mpbc_pkg::NONE_ACTIVE);

            if (!pressed && !held[i] && owner == i && clicks[i] == '0)
            begin
                // The owning button is up with nothing pending: release.
                owner = mpbc_pkg::NONE_ACTIVE;
                r.decided = 1'b1;
                return r;
            end
            else if (!pressed && !held[i] && no_owner && i == BUTTONS - 1
                     && !p.wait_for_press)
            begin
                r.decided = 1'b1;
                return r;
            end
            else if (pressed && !held[i])
            begin
                // A new press takes over and drops clicks of the old owner.
                if (owner != i && owner < BUTTONS)
                begin
                    clicks[owner] = '0;
                end
                press_at[i] = p.now_ms;
                last_change_at[i] = p.now_ms;
                owner = mpbc_pkg::ACT_W'(i);
                if (single_only)
                begin
                    r.decided = 1'b1;
                    r.press_code = BUTTON_CODES[i][mpbc_pkg::COL_SINGLE];
                    return r;
                end
                if (!has_multi && !has_long && !has_repeat)
                begin
                    r.decided = 1'b1;
                    return r;
                end
                held[i] = 1'b1;
            end
            else if (pressed && held[i] && has_long)
            begin
                if (dur >= 32'(timing[mpbc_pkg::REG_LONG_PRESS]))
                begin
                    long_done[i] = 1'b1;
                    r.decided = 1'b1;
                    r.press_code = BUTTON_CODES[i][mpbc_pkg::COL_LONG];
                    return r;
                end
            end
            else if (pressed && held[i] && has_repeat)
            begin
                if (dur >= 32'(timing[mpbc_pkg::REG_REPEAT_PRESS]))
                begin
                    repeat_done[i] = 1'b1;
                    r.decided = 1'b1;
                    r.press_code = BUTTON_CODES[i][mpbc_pkg::COL_REPEAT];
                    r.is_repeat = 1'b1;
                    return r;
                end
            end
            else if (!pressed && held[i] && (long_done[i] || repeat_done[i]))
            begin
                held[i] = 1'b0;
                long_done[i] = 1'b0;
                repeat_done[i] = 1'b0;
                r.decided = 1'b1;
                r.press_code = BUTTON_CODES[i][mpbc_pkg::COL_SINGLE];
                return r;
            end
            else if (!pressed && held[i] && !has_multi)
            begin
                held[i] = 1'b0;
                r.decided = 1'b1;
                r.press_code = BUTTON_CODES[i][mpbc_pkg::COL_SINGLE];
                return r;
            end
            else if (!pressed && held[i] && has_multi)
            begin
                // Only presses longer than the debounce time count as clicks.
                held[i] = 1'b0;
                if (dur > 32'(timing[mpbc_pkg::REG_DEBOUNCE])
                    && clicks[i] < mpbc_pkg::CNT_MAX)
                begin
                    clicks[i] = clicks[i] + mpbc_pkg::CNT_W'(1);
                end
                last_change_at[i] = p.now_ms;
            end

            // Once the quiet gap after the last click has passed, the click
            // count picks the code; anything above six is a sextuple.
            if (!held[i] && clicks[i] != '0 && has_multi)
            begin
                gap = p.now_ms - last_change_at[i];
                n = int'(clicks[i]);
                if (n == 1 && gap > 32'(timing[mpbc_pkg::REG_DOUBLE_GAP]))
                begin
                    clicks[i] = '0;
                    r.decided = 1'b1;
                    r.press_code = BUTTON_CODES[i][mpbc_pkg::COL_SINGLE];
                    return r;
                end
                else if (n >= 2 && gap > 32'(timing[mpbc_pkg::REG_MULTI_GAP]))
                begin
                    clicks[i] = '0;
                    r.decided = 1'b1;
                    r.press_code =
                        BUTTON_CODES[i][(n > 6) ? mpbc_pkg::COL_SEXTUPLE : 3'(n - 1)];
                    return r;
                end
            end
        end
        return r;
    endfunction

    // Driver. A transfer takes place when poll_valid is high and poll_stall
    // is low at the clock edge; the expected code is predicted right there.
    // Polls go out in bursts of random length with random idle gaps between.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            poll_valid <= 1'b0;
        end
        else
        begin
            if (poll_valid && !poll_stall)
            begin
                expected_codes.push_back(classify_poll(poll));
                polls_taken++;
            end
            // A stalled poll stays on the bus unchanged.
            if (!poll_valid || !poll_stall)
            begin
                if (idle_left > 0)
                begin
                    idle_left--;
                    poll_valid <= 1'b0;
                end
                else if (poll_backlog.size() > 0)
                begin
                    poll <= poll_backlog.pop_front();
                    poll_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 24);
                        idle_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                else
                begin
                    poll_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor. Every result transfer is checked against the oldest expected
    // code. The receiver stalls on a pattern picked at random: never, lightly,
    // heavily, or periodically.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_codes.size() == 0)
                begin
                    if (code_errors < 10)
                    begin
                        $display("unexpected result: decided=%0d code=%0d repeat=%0d",
                                 result.decided, result.press_code, result.is_repeat);
                    end
                    code_errors++;
                end
                else if (result.decided !== expected_codes[0].decided
                         || result.press_code !== expected_codes[0].press_code
                         || result.is_repeat !== expected_codes[0].is_repeat)
                begin
                    if (code_errors < 10)
                    begin
                        $display("mismatch (decided code repeat): expected %0d %0d %0d, got %0d %0d %0d",
                                 expected_codes[0].decided, expected_codes[0].press_code,
                                 expected_codes[0].is_repeat, result.decided,
                                 result.press_code, result.is_repeat);
                    end
                    code_errors++;
                    void'(expected_codes.pop_front());
                end
                else
                begin
                    void'(expected_codes.pop_front());
                end
            end
            stall_tick++;
            if (stall_tick % 200 == 0)
            begin
                stall_mode = $urandom_range(0, 3);
            end
            case (stall_mode)
                0: result_stall <= 1'b0;
                1: result_stall <= ($urandom_range(0, 3) == 0);
                2: result_stall <= ($urandom_range(0, 9) < 6);
                default: result_stall <= ((stall_tick % 7) < 3);
            endcase
        end
    end

    // Watchdog: ends the run if no transfer happens on either channel for
    // too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((poll_valid && !poll_stall) || (result_valid && !result_stall))
            begin
                quiet_cycles = 0;
            end
            else
            begin
                quiet_cycles++;
            end
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // Queues one poll, the clock having moved on by dt milliseconds.
    function automatic void add_poll(input logic [8:0] levels, input bit wait_f,
                                     input bit start_f, input int unsigned dt);
        mpbc_pkg::poll_t p;
        clock_ms = clock_ms + dt;
        p.button_bits    = levels[7:0];
        p.moon_pressed   = levels[8];
        p.now_ms         = clock_ms;
        p.wait_for_press = wait_f;
        p.call_start     = start_f;
        poll_backlog.push_back(p);
        polls_queued++;
    endfunction

    // Returns once every queued poll has been taken and answered.
    task automatic wait_drained();
        @(negedge clk);
        while (polls_taken != polls_queued || expected_codes.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Writes all six timing registers; only called while the block is idle.
    task automatic load_timing(input int unsigned lp, input int unsigned rp,
                               input int unsigned db, input int unsigned dg,
                               input int unsigned mg, input int unsigned wt);
        mpbc_pkg::cfg_reg_t              order [6];
        logic [mpbc_pkg::CFG_DATA_W-1:0] vals [6];
        order = '{mpbc_pkg::REG_LONG_PRESS, mpbc_pkg::REG_REPEAT_PRESS,
                  mpbc_pkg::REG_DEBOUNCE, mpbc_pkg::REG_DOUBLE_GAP,
                  mpbc_pkg::REG_MULTI_GAP, mpbc_pkg::REG_WAIT_TIMEOUT};
        vals = '{lp[15:0], rp[15:0], db[15:0], dg[15:0], mg[15:0], wt[15:0]};
        for (int k = 0; k < 6; k++)
        begin
            @(posedge clk);
            cfg_we <= 1'b1;
            cfg_index <= order[k];
            cfg_data <= vals[k];
            @(posedge clk);
            cfg_we <= 1'b0;
            timing[order[k]] = vals[k];
        end
        @(negedge clk);
    endtask

    // A run of clicks on one button followed by quiet polls until the gap
    // has passed, then one more poll so the button gives up the request.
    // Release times straddle the debounce time and some pauses between
    // clicks overrun the gap so that trains also break early.
    task automatic click_train(input int unsigned btn, input int unsigned count,
                               input bit wait_f);
        int unsigned deb;
        int unsigned gap;
        int unsigned elapsed;
        int unsigned dt;
        logic [8:0]  lv;
        deb = 32'(timing[mpbc_pkg::REG_DEBOUNCE]);
        gap = (count > 1) ? 32'(timing[mpbc_pkg::REG_MULTI_GAP])
                          : 32'(timing[mpbc_pkg::REG_DOUBLE_GAP]);
        lv = 9'(1 << btn);
        for (int k = 0; k < count; k++)
        begin
            if (k == 0)
            begin
                add_poll(lv, wait_f, 1'($urandom_range(0, 1)), $urandom_range(0, 50));
            end
            else if ($urandom_range(0, 7) == 0)
            begin
                add_poll(lv, wait_f, 1'b0, gap + $urandom_range(1, 50));
            end
            else
            begin
                add_poll(lv, wait_f, 1'b0, $urandom_range(0, gap));
            end
            if ($urandom_range(0, 3) == 0)
            begin
                add_poll(lv, wait_f, 1'b0, $urandom_range(0, deb / 2 + 1));
            end
            add_poll('0, wait_f, 1'b0, $urandom_range(deb / 2, 2 * deb + 2));
        end
        gap = (timing[mpbc_pkg::REG_MULTI_GAP] > timing[mpbc_pkg::REG_DOUBLE_GAP])
              ? 32'(timing[mpbc_pkg::REG_MULTI_GAP])
              : 32'(timing[mpbc_pkg::REG_DOUBLE_GAP]);
        elapsed = 0;
        while (elapsed <= gap)
        begin
            dt = $urandom_range(1, gap / 3 + 1);
            add_poll('0, wait_f, 1'b0, dt);
            elapsed += dt;
        end
        add_poll('0, 1'b0, 1'b0, 1);
    endtask

    // Holds a button to around the long-press time; a quarter of the holds
    // end early.
    task automatic long_hold(input int unsigned btn);
        int unsigned lp;
        int unsigned target;
        int unsigned elapsed;
        int unsigned dt;
        logic [8:0]  lv;
        lp = 32'(timing[mpbc_pkg::REG_LONG_PRESS]);
        target = ($urandom_range(0, 3) == 0) ? lp / 2 : lp + $urandom_range(0, 3);
        lv = 9'(1 << btn);
        add_poll(lv, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                 $urandom_range(0, 30));
        elapsed = 0;
        do
        begin
            dt = $urandom_range(1, lp / 3 + 1);
            add_poll(lv, 1'b0, 1'b0, dt);
            elapsed += dt;
        end
        while (elapsed < target);
        add_poll('0, 1'b0, 1'b0, $urandom_range(0, 20));
        add_poll('0, 1'b0, 1'b0, 1);
    endtask

    // A waiting request with no buttons, run on until the timeout.
    task automatic idle_wait();
        int unsigned limit;
        int unsigned elapsed;
        int unsigned dt;
        limit = 32'(timing[mpbc_pkg::REG_WAIT_TIMEOUT]);
        add_poll('0, 1'b1, 1'b1, $urandom_range(0, 20));
        elapsed = 0;
        while (elapsed < limit)
        begin
            dt = $urandom_range(1, limit / 3 + 1);
            add_poll('0, 1'b1, 1'b0, dt);
            elapsed += dt;
        end
    endtask

    initial
    begin
        int unsigned pick;
        int unsigned first_poll;
        int unsigned btn;
        bit          paused;

        for (int i = 0; i < BUTTONS; i++)
        begin
            clicks[i] = '0;
            press_at[i] = '0;
            last_change_at[i] = '0;
            held[i] = 1'b0;
            long_done[i] = 1'b0;
            repeat_done[i] = 1'b0;
        end
        owner = mpbc_pkg::NONE_ACTIVE;
        request_at = '0;
        timing[mpbc_pkg::REG_LONG_PRESS]   = mpbc_pkg::LONG_PRESS_RST;
        timing[mpbc_pkg::REG_REPEAT_PRESS] = mpbc_pkg::REPEAT_PRESS_RST;
        timing[mpbc_pkg::REG_DEBOUNCE]     = mpbc_pkg::DEBOUNCE_RST;
        timing[mpbc_pkg::REG_DOUBLE_GAP]   = mpbc_pkg::DOUBLE_GAP_RST;
        timing[mpbc_pkg::REG_MULTI_GAP]    = mpbc_pkg::MULTI_GAP_RST;
        timing[mpbc_pkg::REG_WAIT_TIMEOUT] = mpbc_pkg::WAIT_TIMEOUT_RST;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        load_timing(800, 500, 50, 300, 300, 5000);

        // Directed part under the default timing, with the clock wrapping
        // through zero: idle release, a wait that times out, a single press,
        // a long press on the sleep button, a double click and a single click on
        // two multi-press buttons, a click too short to count, and every button
        // at once at the top of the time range.
        clock_ms = 32'hFFFF_FE00;
        add_poll(9'h000, 1'b0, 1'b1, 0);
        add_poll(9'h000, 1'b1, 1'b1, 0);
        add_poll(9'h000, 1'b1, 1'b0, 5000);
        add_poll(9'h001, 1'b0, 1'b0, 10);
        add_poll(9'h001, 1'b0, 1'b0, 100);
        add_poll(9'h000, 1'b0, 1'b0, 20);
        add_poll(9'h000, 1'b0, 1'b0, 5);
        add_poll(9'h100, 1'b0, 1'b0, 7);
        add_poll(9'h100, 1'b0, 1'b0, 900);
        add_poll(9'h000, 1'b0, 1'b0, 3);
        add_poll(9'h004, 1'b0, 1'b0, 10);
        add_poll(9'h000, 1'b0, 1'b0, 60);
        add_poll(9'h004, 1'b0, 1'b0, 100);
        add_poll(9'h000, 1'b0, 1'b0, 60);
        add_poll(9'h000, 1'b0, 1'b0, 400);
        add_poll(9'h000, 1'b0, 1'b0, 1);
        add_poll(9'h008, 1'b0, 1'b0, 10);
        add_poll(9'h000, 1'b0, 1'b0, 60);
        add_poll(9'h000, 1'b0, 1'b0, 301);
        add_poll(9'h010, 1'b0, 1'b0, 5);
        add_poll(9'h000, 1'b0, 1'b0, 10);
        add_poll(9'h000, 1'b0, 1'b0, 1);
        add_poll(9'h1FF, 1'b1, 1'b1, 0);
        clock_ms = 32'hFFFF_FFFF;
        add_poll(9'h1FF, 1'b1, 1'b0, 0);
        add_poll(9'h000, 1'b1, 1'b0, 1);
        wait_drained();

        // Random phases, each with its own timing: all zero, all maximum,
        // small values, a click-count saturation setup, full range, and the
        // defaults. Halfway through each phase the sender waits for every
        // outstanding code before going on.
        for (int ph = 0; ph < 7; ph++)
        begin
            case (ph)
                0: load_timing(0, 0, 0, 0, 0, 0);
                1: load_timing(65535, 65535, 65535, 65535, 65535, 65535);
                2: load_timing($urandom_range(0, 200), $urandom_range(0, 200),
                               $urandom_range(0, 200), $urandom_range(0, 200),
                               $urandom_range(0, 200), $urandom_range(0, 200));
                3: load_timing($urandom_range(1000, 65535), $urandom_range(0, 65535), 0,
                               $urandom_range(0, 500), 65535, 65535);
                4: load_timing($urandom_range(0, 65535), $urandom_range(0, 65535),
                               $urandom_range(0, 65535), $urandom_range(0, 65535),
                               $urandom_range(0, 65535), $urandom_range(0, 65535));
                default: load_timing(800, 500, 50, 300, 300, 5000);
            endcase
            clock_ms = $urandom;
            first_poll = polls_queued;
            paused = 1'b0;
            if (ph == 3)
            begin
                // With no debounce and the widest gap, 270 quick clicks drive
                // the click count into saturation before the sextuple code.
                btn = $urandom_range(2, 5);
                repeat (270)
                begin
                    add_poll(9'(1 << btn), 1'b0, 1'b0, 1);
                    add_poll(9'h000, 1'b0, 1'b0, 1);
                end
                add_poll(9'h000, 1'b0, 1'b0, 40000);
                add_poll(9'h000, 1'b0, 1'b0, 40000);
                add_poll(9'h000, 1'b0, 1'b0, 1);
            end
            while (polls_queued - first_poll < PHASE_POLLS + ((ph == 3) ? 543 : 0))
            begin
                if (!paused && polls_queued - first_poll >= PHASE_POLLS / 2)
                begin
                    wait_drained();
                    paused = 1'b1;
                end
                pick = $urandom_range(0, 99);
                btn = $urandom_range(0, BUTTONS - 1);
                if (pick < 35)
                begin
                    click_train($urandom_range(2, 5), $urandom_range(1, 8),
                                1'($urandom_range(0, 1)));
                end
                else if (pick < 50)
                begin
                    click_train(btn, $urandom_range(1, 3), 1'($urandom_range(0, 1)));
                end
                else if (pick < 65)
                begin
                    long_hold(btn);
                end
                else if (pick < 80)
                begin
                    idle_wait();
                end
                else
                begin
                    // Noise: random levels and flags, sometimes a wild jump
                    // in time.
                    repeat ($urandom_range(1, 6))
                    begin
                        add_poll(9'($urandom), 1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1)),
                                 ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 400));
                    end
                end
            end
            wait_drained();
        end

        repeat (6) @(posedge clk);
        if (code_errors == 0 && expected_codes.size() == 0)
        begin
            $display("Verification passed");
        end
        else
        begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule
